// ===== design/stq_pkg.sv =====
`timescale 1ns / 1ps

package stq_pkg;

  localparam int unsigned NumSlotsDefault = 16;
  localparam int unsigned ExpiryWidth     = 64;
  localparam int unsigned SlotWidth       = 4;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_MODIFY = 2'd3
  } mode_e;

  localparam logic KindStatus = 1'b0;
  localparam logic KindFired  = 1'b1;

  // Outcome of comparing one stored expiry against the tick count and the
  // best candidate found so far in the current scan.
  typedef struct packed {
    logic le_now;
    logic lt_best;
  } cmp_res_t;

endpackage

// ===== design/stq_cmp.sv =====
`timescale 1ns / 1ps

module stq_cmp
  import stq_pkg::*;
(
  input  logic [ExpiryWidth-1:0] entry_i,
  input  logic [ExpiryWidth-1:0] now_i,
  input  logic [ExpiryWidth-1:0] best_i,
  output cmp_res_t               res_o
);

  assign res_o.le_now  = (entry_i <= now_i);
  assign res_o.lt_best = (entry_i < best_i);

endmodule

// ===== design/software_timer_queue.sv =====
`timescale 1ns / 1ps

// Timer slot queue with NUM_SLOTS slots, each holding a 64-bit expiry and an
// active flag. Items enter on the in_* channel (valid/ready) and results leave
// on the out_* channel (valid/ready) through a single output register.
// Add, delete and modify are accepted while idle and their status beat is
// presented on the next cycle; they sustain one item per cycle while the
// receiver keeps up.
// A tick scans the expiry memory one slot per cycle through a single
// comparator. Each scan visits every slot and yields the earliest expired
// slot, so a tick firing k slots runs max(k, 1) scans. The last fired beat
// carries last = 1; a tick that fires nothing produces no beat.
// The scan length is set by the one-read-per-cycle port of the expiry memory.
// Reset clears all active flags at once; the expiry memory needs no clearing,
// since an entry is only consulted while its slot is armed.
// When the receiver stalls, the pending beat holds in the output register and
// the block stops taking items or emitting fired slots until it drains.
module software_timer_queue
  import stq_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NumSlotsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             mode_i,
  input  logic [SlotWidth-1:0]   slot_i,
  input  logic [ExpiryWidth-1:0] expiry_i,
  input  logic [ExpiryWidth-1:0] now_ticks_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   kind_o,
  output logic [SlotWidth-1:0]   slot_out_o,
  output logic                   prior_armed_o,
  output logic                   last_o
);

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
  localparam logic [IW-1:0] LastIdx = IW'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [ExpiryWidth-1:0] expiry_mem [NUM_SLOTS];
  logic [ExpiryWidth-1:0] rd_data_q;
  logic [NUM_SLOTS-1:0]   active_q, active_d;

  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic          rd_on_q, rd_on_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;
  logic          cmp_v_q, cmp_v_d;

  logic [ExpiryWidth-1:0] now_q, now_d;
  logic [ExpiryWidth-1:0] best_exp_q, best_exp_d;
  logic [IW-1:0]          best_idx_q, best_idx_d;
  logic [CW-1:0]          count_q, count_d;

  logic                 out_valid_q, out_valid_d;
  logic                 kind_q, kind_d;
  logic [SlotWidth-1:0] slot_out_q, slot_out_d;
  logic                 was_q, was_d;
  logic                 last_q, last_d;

  mode_e         mode;
  logic          in_fire;
  logic          out_free;
  logic          out_load;
  logic          slot_ok;
  logic [IW-1:0] slot_idx;
  logic          mem_we;
  logic          qual;
  cmp_res_t      cmp_res;

  assign mode     = mode_e'(mode_i);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire  = in_valid_i && in_ready_o;
  assign slot_ok  = (32'(slot_i) < NUM_SLOTS);
  assign slot_idx = IW'(slot_i);
  assign mem_we   = in_fire && slot_ok && (mode == MODE_ADD || mode == MODE_MODIFY);

  stq_cmp u_cmp (
    .entry_i (rd_data_q),
    .now_i   (now_q),
    .best_i  (best_exp_q),
    .res_o   (cmp_res)
  );

  assign qual = cmp_v_q && active_q[cmp_idx_q] && cmp_res.le_now;

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    rd_idx_d    = rd_idx_q;
    rd_on_d     = rd_on_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_v_d     = 1'b0;
    now_d       = now_q;
    best_exp_d  = best_exp_q;
    best_idx_d  = best_idx_q;
    count_d     = count_q;
    out_load    = 1'b0;
    kind_d      = kind_q;
    slot_out_d  = slot_out_q;
    was_d       = was_q;
    last_d      = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (mode == MODE_TICK) begin
            now_d    = now_ticks_i;
            rd_idx_d = '0;
            rd_on_d  = 1'b1;
            count_d  = '0;
            state_d  = ST_SCAN;
          end else begin
            out_load   = 1'b1;
            kind_d     = KindStatus;
            slot_out_d = slot_i;
            was_d      = slot_ok && active_q[slot_idx];
            last_d     = 1'b1;
            if (slot_ok) begin
              active_d[slot_idx] = (mode != MODE_DELETE);
            end
          end
        end
      end
      ST_SCAN: begin
        if (rd_on_q) begin
          cmp_v_d   = 1'b1;
          cmp_idx_d = rd_idx_q;
          if (rd_idx_q == LastIdx) begin
            rd_on_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + IW'(1);
          end
        end
        if (qual) begin
          count_d = count_q + CW'(1);
          // Ties keep the lower slot, since slots are visited in ascending order.
          if (count_q == '0 || cmp_res.lt_best) begin
            best_exp_d = rd_data_q;
            best_idx_d = cmp_idx_q;
          end
        end
        if (cmp_v_q && cmp_idx_q == LastIdx) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (count_q == '0) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          kind_d     = KindFired;
          slot_out_d = SlotWidth'(best_idx_q);
          was_d      = 1'b1;
          last_d     = (count_q == CW'(1));
          active_d[best_idx_q] = 1'b0;
          if (count_q == CW'(1)) begin
            state_d = ST_IDLE;
          end else begin
            rd_idx_d = '0;
            rd_on_d  = 1'b1;
            count_d  = '0;
            state_d  = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      rd_on_q     <= 1'b0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      rd_on_q     <= rd_on_d;
      cmp_v_q     <= cmp_v_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    now_q      <= now_d;
    best_exp_q <= best_exp_d;
    best_idx_q <= best_idx_d;
    kind_q     <= kind_d;
    slot_out_q <= slot_out_d;
    was_q      <= was_d;
    last_q     <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      expiry_mem[slot_idx] <= expiry_i;
    end
    rd_data_q <= expiry_mem[rd_idx_q];
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign slot_out_o    = slot_out_q;
  assign prior_armed_o = was_q;
  assign last_o        = last_q;

endmodule

// ===== design/stq_checker.sv =====
`timescale 1ns / 1ps

module stq_checker
  import stq_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic [1:0]           mode_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic                 kind_i,
  input logic [SlotWidth-1:0] slot_out_i,
  input logic                 prior_armed_i,
  input logic                 last_i
);

  // A stalled result beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(kind_i) && $stable(slot_out_i) &&
      $stable(prior_armed_i) && $stable(last_i))
    else $error("stalled result beat changed");

  // New items are refused while the output register is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output register blocked");

  // Add, delete and modify produce their status beat on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && mode_i != MODE_TICK |=>
      out_valid_i && kind_i == KindStatus && last_i)
    else $error("status beat missing after slot operation");

  // A fired slot always reports that it was armed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KindFired |-> prior_armed_i)
    else $error("fired beat with prior_armed clear");

endmodule

bind software_timer_queue stq_checker u_stq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_i    (in_ready_o),
  .mode_i        (mode_i),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .kind_i        (kind_o),
  .slot_out_i    (slot_out_o),
  .prior_armed_i (prior_armed_o),
  .last_i        (last_o)
);

// ===== test/stq_beat_checker.sv =====
`timescale 1ns / 1ps

module stq_beat_checker
  import stq_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NumSlotsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [1:0]             mode_i,
  input  logic [SlotWidth-1:0]   slot_i,
  input  logic [ExpiryWidth-1:0] expiry_i,
  input  logic [ExpiryWidth-1:0] now_ticks_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic                   kind_i,
  input  logic [SlotWidth-1:0]   slot_out_i,
  input  logic                   prior_armed_i,
  input  logic                   last_i,
  input  logic                   sweep_i,
  output int unsigned            pending_o,
  output int unsigned            beats_o,
  output int unsigned            fired_o,
  output int unsigned            errors_o
);

  localparam int unsigned MaxFired = 16;

  typedef struct packed {
    logic                 kind;
    logic [SlotWidth-1:0] slot;
    logic                 prior_armed;
    logic                 last;
  } timer_beat_t;

  logic [ExpiryWidth-1:0] stored_expiry [NUM_SLOTS];
  logic                   armed         [NUM_SLOTS];
  timer_beat_t            timer_beats_due [$];
  int unsigned            mismatches;
  int unsigned            beats_seen;
  int unsigned            fired_seen;
  logic                   swept;

  task automatic report_mismatch(input string what);
    $display("[%0t] timer queue mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Applies one operation to the shadow slot bank and queues the beats it causes.
  function automatic void apply_timer_op(input mode_e op, input logic [SlotWidth-1:0] slot,
                                         input logic [ExpiryWidth-1:0] new_expiry,
                                         input logic [ExpiryWidth-1:0] now);
    timer_beat_t beat;
    int          best;
    int unsigned n_fired;
    logic        was;
    n_fired = 0;
    was     = 1'b0;
    if (op == MODE_TICK) begin
      // Each pass picks the earliest expired slot; strict compare keeps the lower slot on ties.
      do begin
        best = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (armed[i] && stored_expiry[i] <= now) begin
            if (best < 0) best = i;
            else if (stored_expiry[i] < stored_expiry[best]) best = i;
          end
        end
        if (best >= 0) begin
          armed[best]      = 1'b0;
          beat.kind        = KindFired;
          beat.slot        = SlotWidth'(best);
          beat.prior_armed = 1'b1;
          beat.last        = 1'b0;
          timer_beats_due.push_back(beat);
          n_fired++;
        end
      end while (best >= 0 && n_fired < MaxFired);
      if (n_fired > 0) timer_beats_due[timer_beats_due.size() - 1].last = 1'b1;
    end else begin
      if (slot < NUM_SLOTS) begin
        was = armed[slot];
        if (op == MODE_DELETE) begin
          armed[slot] = 1'b0;
        end else begin
          stored_expiry[slot] = new_expiry;
          armed[slot]         = 1'b1;
        end
      end
      beat.kind        = KindStatus;
      beat.slot        = slot;
      beat.prior_armed = was;
      beat.last        = 1'b1;
      timer_beats_due.push_back(beat);
    end
  endfunction

  task automatic check_beat();
    timer_beat_t want;
    if (timer_beats_due.size() == 0) begin
      report_mismatch($sformatf("unexpected beat kind %0d slot %0d prior_armed %0d last %0d",
                                kind_i, slot_out_i, prior_armed_i, last_i));
    end else begin
      want = timer_beats_due.pop_front();
      if (kind_i !== want.kind || slot_out_i !== want.slot ||
          prior_armed_i !== want.prior_armed || last_i !== want.last) begin
        report_mismatch($sformatf(
          "kind %0d/%0d slot %0d/%0d prior_armed %0d/%0d last %0d/%0d (got/expected)",
          kind_i, want.kind, slot_out_i, want.slot, prior_armed_i, want.prior_armed,
          last_i, want.last));
      end
    end
    beats_seen++;
    if (kind_i === KindFired) fired_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        armed[i]         = 1'b0;
        stored_expiry[i] = '0;
      end
      timer_beats_due.delete();
      pending_o <= 0;
    end else begin
      // An output beat at this edge always belongs to an item taken at an earlier edge.
      if (out_valid_i && out_ready_i) check_beat();
      if (in_valid_i && in_ready_i) begin
        apply_timer_op(mode_e'(mode_i), slot_i, expiry_i, now_ticks_i);
      end
      if (sweep_i && !swept) begin
        swept = 1'b1;
        while (timer_beats_due.size() != 0) begin
          void'(timer_beats_due.pop_front());
          report_mismatch("expected beat never arrived");
        end
      end
      pending_o <= timer_beats_due.size();
    end
    errors_o <= mismatches;
    beats_o  <= beats_seen;
    fired_o  <= fired_seen;
  end

  initial begin
    mismatches = 0;
    beats_seen = 0;
    fired_seen = 0;
    swept      = 1'b0;
    pending_o  = 0;
    errors_o   = 0;
    beats_o    = 0;
    fired_o    = 0;
  end

endmodule

// ===== test/tb_software_timer_queue.sv =====
`timescale 1ns / 1ps

module tb_software_timer_queue;
  import stq_pkg::*;

  localparam int unsigned NumSlots    = NumSlotsDefault;
  localparam int unsigned RandomItems = 93;
  localparam int unsigned HoldCycles  = 250;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 4 * (NumSlots + 2);
  localparam logic [ExpiryWidth-1:0] MaxTicks = '1;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic [1:0]             mode_i      = MODE_TICK;
  logic [SlotWidth-1:0]   slot_i      = '0;
  logic [ExpiryWidth-1:0] expiry_i    = '0;
  logic [ExpiryWidth-1:0] now_ticks_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   kind_o;
  logic [SlotWidth-1:0]   slot_out_o;
  logic                   prior_armed_o;
  logic                   last_o;

  logic                   steady      = 1'b0;
  logic                   sweep       = 1'b0;
  logic                   run_done    = 1'b0;
  int unsigned            hold_asked  = 0;
  int unsigned            hold_taken  = 0;
  int unsigned            quiet_cycles = 0;
  int unsigned            ops_sent [4];
  int unsigned            pending, beats_checked, fired_checked, mismatches;

  software_timer_queue #(
    .NUM_SLOTS(NumSlots)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .slot_i       (slot_i),
    .expiry_i     (expiry_i),
    .now_ticks_i  (now_ticks_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .slot_out_o   (slot_out_o),
    .prior_armed_o(prior_armed_o),
    .last_o       (last_o)
  );

  stq_beat_checker #(
    .NUM_SLOTS(NumSlots)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .mode_i       (mode_i),
    .slot_i       (slot_i),
    .expiry_i     (expiry_i),
    .now_ticks_i  (now_ticks_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_i       (kind_o),
    .slot_out_i   (slot_out_o),
    .prior_armed_i(prior_armed_o),
    .last_i       (last_o),
    .sweep_i      (sweep),
    .pending_o    (pending),
    .beats_o      (beats_checked),
    .fired_o      (fired_checked),
    .errors_o     (mismatches)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Offers one item after an optional random gap and returns at the edge that takes it.
  task automatic send_item(input mode_e op, input logic [SlotWidth-1:0] slot,
                           input logic [ExpiryWidth-1:0] new_expiry,
                           input logic [ExpiryWidth-1:0] now);
    while (!steady && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= op;
    slot_i      <= slot;
    expiry_i    <= new_expiry;
    now_ticks_i <= now;
    do @(posedge clk_i); while (!in_ready_o);
    ops_sent[op]++;
  endtask

  task automatic send_tick(input logic [ExpiryWidth-1:0] now);
    send_item(MODE_TICK, SlotWidth'($urandom_range(15)), {$urandom(), $urandom()}, now);
  endtask

  task automatic send_slot_op(input mode_e op, input logic [SlotWidth-1:0] slot,
                              input logic [ExpiryWidth-1:0] new_expiry);
    send_item(op, slot, new_expiry, {$urandom(), $urandom()});
  endtask

  // Receiver: random stalls, plus one long hold-off when the sender asks for it.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready_i <= steady || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !run_done) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("timeout: no beat moved for %0d cycles", StallLimit);
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [ExpiryWidth-1:0] base;
    logic [ExpiryWidth-1:0] now;
    int unsigned            rand_items;
    int unsigned            full_bursts;
    int unsigned            pick;
    int unsigned            n_ops;
    mode_e                  op;

    for (int i = 0; i < 4; i++) ops_sent[i] = 0;
    base        = 64'd1000;
    rand_items  = 0;
    full_bursts = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty bank, extremes, ties, re-arming and idle deletes.
    send_tick(MaxTicks);                       // nothing armed: no beat at all
    send_slot_op(MODE_DELETE, 4'd3, '0);       // delete of an idle slot
    send_slot_op(MODE_ADD, 4'd0, '0);
    send_tick('0);                             // expiry equal to the count fires
    send_slot_op(MODE_ADD, 4'd15, MaxTicks);
    send_slot_op(MODE_ADD, 4'd7, 64'd100);
    send_slot_op(MODE_ADD, 4'd7, 64'd50);      // add on an armed slot re-arms it
    send_slot_op(MODE_MODIFY, 4'd9, 64'd50);   // modify of an idle slot arms it
    send_slot_op(MODE_ADD, 4'd0, 64'd30);
    send_slot_op(MODE_MODIFY, 4'd0, 64'd20);
    send_slot_op(MODE_ADD, 4'd4, 64'd20);
    send_tick(64'd19);                         // one below the earliest: nothing fires
    send_tick(64'd50);                         // equal expiries fire by slot number
    send_slot_op(MODE_DELETE, 4'd15, '0);
    send_slot_op(MODE_DELETE, 4'd15, '0);
    send_slot_op(MODE_MODIFY, 4'd15, MaxTicks);
    send_tick(MaxTicks);

    // Random part: mostly batches of slot operations closed by a tick that
    // advances time, with full-bank bursts and unconstrained noise mixed in.
    while (rand_items < RandomItems) begin
      if (rand_items >= 55 && rand_items < 85) steady <= 1'b1;
      else steady <= 1'b0;
      pick = $urandom_range(99);
      if (hold_asked == 0 && rand_items >= 30) begin
        // Long receiver hold-off while slot operations wait behind the held status beat.
        hold_asked <= hold_asked + 1;
        for (int i = 0; i < 8; i++) begin
          send_slot_op(MODE_ADD, SlotWidth'($urandom_range(15)),
                       base + 64'($urandom_range(200, 400)));
        end
        rand_items += 8;
      end else if (pick < 10 && full_bursts < 3) begin
        // Arm every slot, then fire them all with one tick.
        for (int i = 0; i < NumSlots; i++) begin
          send_slot_op(MODE_ADD, SlotWidth'(i), base + 64'($urandom_range(7)));
        end
        base = base + 64'd8;
        send_tick(base);
        full_bursts++;
        rand_items += NumSlots + 1;
      end else if (pick < 82) begin
        n_ops = $urandom_range(1, 6);
        for (int i = 0; i < n_ops; i++) begin
          pick = $urandom_range(99);
          op   = (pick < 55) ? MODE_ADD : (pick < 78) ? MODE_MODIFY : MODE_DELETE;
          send_slot_op(op, SlotWidth'($urandom_range(15)),
                       base + 64'($urandom_range(60)));
        end
        now  = base + 64'($urandom_range(50));
        base = now;
        send_tick(now);
        rand_items += n_ops + 1;
      end else begin
        send_item(mode_e'($urandom_range(3)), SlotWidth'($urandom_range(15)),
                  {$urandom(), $urandom()}, {$urandom(), $urandom()});
        rand_items++;
      end
    end
    steady     <= 1'b0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    // A tick that fires nothing can still be scanning here.
    repeat (DrainCycles) @(posedge clk_i);
    run_done <= 1'b1;
    sweep    <= 1'b1;
    repeat (2) @(posedge clk_i);

    $display("Sent %0d ticks, %0d adds, %0d deletes, %0d modifies.",
             ops_sent[MODE_TICK], ops_sent[MODE_ADD], ops_sent[MODE_DELETE],
             ops_sent[MODE_MODIFY]);
    $display("Checked %0d result beats, %0d of them fired timers; %0d mismatches.",
             beats_checked, fired_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
